// File: rtl/core/ipq_pkg.sv
// Shared types, widths and constants (characters, octet limits) for the dotted-quad IPv4 parser.
`timescale 1ns / 1ps
`default_nettype none

package ipq_pkg;

    localparam int CHAR_W = 8;
    localparam int ADDR_W = 32;
    localparam int OCTET_W = 8;
    localparam int ACC_W = 9;
    localparam int PROD_W = 12;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ACC_W-1:0]   acc_t;
    typedef logic [1:0]         seg_idx_t;
    typedef logic [3*OCTET_W-1:0] octets_t;

    localparam char_t    CHAR_END  = 8'h00;
    localparam char_t    CHAR_DOT  = 8'h2E;
    localparam char_t    CHAR_ZERO = 8'h30;
    localparam char_t    CHAR_NINE = 8'h39;
    localparam acc_t     OCTET_MAX = 9'd255;
    localparam acc_t     OCTET_SAT = 9'd256;
    localparam seg_idx_t LAST_SEGMENT = 2'd3;

endpackage

`default_nettype wire

// File: rtl/core/ipq_char_if.sv
// Valid/ready channel carrying one character of a name per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ipq_char_if;
    import ipq_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ipq_result_if.sv
// Valid/ready channel carrying one parse result per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ipq_result_if;
    import ipq_pkg::*;

    logic  valid;
    logic  ready;
    logic  is_address;
    addr_t address;

    modport source (output valid, output is_address, output address, input ready);
    modport sink   (input valid, input is_address, input address, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ipv4_dotted_quad_parser.sv
// Dotted-quad IPv4 parser: one character per beat in, one result per name out.
//
// chars:  one byte of a name per beat; a zero byte ends the name.
// result: one beat per name, sent for its terminator: is_address and the
//         packed address (first octet in bits 31..24, zero when invalid).
// Every other byte produces no result beat.
// Throughput: one character per cycle, except while a terminator stalls as below.
// Each byte is captured in an input register, the parser state is updated
// from it, and a terminator's result is loaded into the output register then.
// Stall: while a result waits in the output register, non-terminator bytes
// keep flowing; a second terminator holds in the input register until the
// waiting result is taken, and chars.ready drops behind it.
// Reset: parser state returns to the start of a name, both registers empty.
// MAX_SEGMENT_CHARS bounds the characters per segment (3..31).
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_quad_parser #(
    parameter int MAX_SEGMENT_CHARS = 15
) (
    input  wire           clk,
    input  wire           rst_n,
    ipq_char_if.sink      chars,
    ipq_result_if.source  result
);
    import ipq_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENT_CHARS + 1);
    localparam logic [CNT_W-1:0] SEG_LIMIT = CNT_W'(MAX_SEGMENT_CHARS);

    logic             in_valid_reg;
    char_t            in_char_reg;

    seg_idx_t         seg_idx_reg, seg_idx_next;
    logic [CNT_W-1:0] seg_chars_reg, seg_chars_next;
    acc_t             octet_reg, octet_next;
    logic             in_run_reg, in_run_next;
    logic             failed_reg, failed_next;
    octets_t          octets_reg, octets_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_is_addr_reg;
    addr_t            out_addr_reg;

    logic             is_end, is_dot, is_digit;
    logic             advance, load_out, accept;
    logic             ok;
    logic [PROD_W-1:0] prod;

    assign is_end   = (in_char_reg == CHAR_END);
    assign is_dot   = (in_char_reg == CHAR_DOT);
    assign is_digit = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);

    assign advance  = in_valid_reg && (!is_end || !out_valid_reg || result.ready);
    assign load_out = advance && is_end;
    assign accept   = chars.valid && chars.ready;

    assign chars.ready = !in_valid_reg || advance;

    assign prod = PROD_W'(octet_reg) * PROD_W'(10)
                + PROD_W'(in_char_reg - CHAR_ZERO);

    assign ok = !failed_reg && (seg_idx_reg == LAST_SEGMENT)
              && (seg_chars_reg != '0) && (octet_reg <= OCTET_MAX);

    always_comb
    begin
        seg_idx_next   = seg_idx_reg;
        seg_chars_next = seg_chars_reg;
        octet_next     = octet_reg;
        in_run_next    = in_run_reg;
        failed_next    = failed_reg;
        octets_next    = octets_reg;
        if (advance)
        begin
            if (is_end)
            begin
                seg_idx_next   = '0;
                seg_chars_next = '0;
                octet_next     = '0;
                in_run_next    = 1'b1;
                failed_next    = 1'b0;
                octets_next    = '0;
            end
            else if (!failed_reg)
            begin
                if (is_dot)
                begin
                    if ((seg_chars_reg == '0) || (seg_idx_reg == LAST_SEGMENT)
                        || (octet_reg > OCTET_MAX))
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        octets_next    = {octets_reg[2*OCTET_W-1:0], octet_reg[OCTET_W-1:0]};
                        seg_idx_next   = seg_idx_reg + 2'd1;
                        seg_chars_next = '0;
                        octet_next     = '0;
                        in_run_next    = 1'b1;
                    end
                end
                else if ((seg_chars_reg == '0) && !is_digit)
                begin
                    failed_next = 1'b1;
                end
                else if (seg_chars_reg >= SEG_LIMIT)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    seg_chars_next = seg_chars_reg + CNT_W'(1);
                    if (in_run_reg)
                    begin
                        if (is_digit)
                            octet_next = (prod > PROD_W'(OCTET_SAT)) ? OCTET_SAT
                                                                     : prod[ACC_W-1:0];
                        else
                            in_run_next = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            seg_idx_reg   <= '0;
            seg_chars_reg <= '0;
            octet_reg     <= '0;
            in_run_reg    <= 1'b1;
            failed_reg    <= 1'b0;
            octets_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (chars.ready)
                in_valid_reg <= chars.valid;
            seg_idx_reg   <= seg_idx_next;
            seg_chars_reg <= seg_chars_next;
            octet_reg     <= octet_next;
            in_run_reg    <= in_run_next;
            failed_reg    <= failed_next;
            octets_reg    <= octets_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_char_reg <= chars.character;
        if (load_out)
        begin
            out_is_addr_reg <= ok;
            out_addr_reg    <= ok ? {octets_reg, octet_reg[OCTET_W-1:0]} : '0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.is_address = out_is_addr_reg;
    assign result.address    = out_addr_reg;

endmodule

`default_nettype wire
